/* rtl/tfc_pkg.sv */
`default_nettype none

package tfc_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF     = 32;
  localparam int unsigned SPAN_BITS         = 15;
  localparam int unsigned NOW_BITS          = 32;

  localparam logic [2:0] VIEW_EMPTY = 3'd0;
  localparam logic [2:0] VIEW_SOLID = 3'd1;
  localparam logic [2:0] VIEW_WATER = 3'd2;
  localparam logic [2:0] VIEW_SLIME = 3'd3;
  localparam logic [2:0] VIEW_LAVA  = 3'd4;

  localparam logic [1:0] FOG_MODE_GLOBAL    = 2'd0;
  localparam logic [1:0] FOG_MODE_WATER_LIN = 2'd1;
  localparam logic [1:0] FOG_MODE_WATER_EXP = 2'd2;

  localparam logic KIND_FRAME   = 1'b0;
  localparam logic KIND_SETTING = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [NOW_BITS-1:0]  now;
    logic [2:0]           view_contents;
    logic [7:0]           new_density;
    logic [7:0]           new_red;
    logic [7:0]           new_green;
    logic [7:0]           new_blue;
    logic [SPAN_BITS-1:0] fade_length;
  } tfc_in_t;

  typedef struct packed {
    logic [7:0] out_density;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       water_active;
    logic [1:0] fog_mode;
  } tfc_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // unknown liquids fall back to water
  function automatic rgb_t liquid_colour(input logic [2:0] contents);
    rgb_t c;
    case (contents)
      VIEW_LAVA:  c = '{red: 8'd255, green: 8'd80,  blue: 8'd0};
      VIEW_SLIME: c = '{red: 8'd10,  green: 8'd188, blue: 8'd85};
      default:    c = '{red: 8'd10,  green: 8'd149, blue: 8'd226};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/tfc_stream_if.sv */
`default_nettype none

interface tfc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/tfc_div.sv */
`default_nettype none

module tfc_div #(
  parameter int unsigned FRACTION_BITS = tfc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         start_i,
  input  wire logic [FRACTION_BITS+tfc_pkg::SPAN_BITS-1:0]  numer_i,
  input  wire logic [tfc_pkg::SPAN_BITS-1:0]                divisor_i,
  output logic                                              done_o,
  output logic [FRACTION_BITS-1:0]                          quot_o
);

  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned SB = tfc_pkg::SPAN_BITS;
  localparam int unsigned NW = FB + SB;
  localparam int unsigned CW = $clog2(FB + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SB-1:0] rem_q, rem_d;
  logic [FB-1:0] low_q, low_d;
  logic [SB-1:0] dvs_q, dvs_d;

  logic [SB:0]   trial;
  logic [SB:0]   trial_sub;
  logic          ge;

  assign trial     = {rem_q, low_q[FB-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(FB);
      rem_d  = numer_i[NW-1:FB];
      low_d  = numer_i[FB-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? trial_sub[SB-1:0] : trial[SB-1:0];
      low_d = {low_q[FB-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

`default_nettype wire

/* rtl/timed_fog_crossfade.sv */
// a frame result is registered after the per-channel blend, and the next word can be taken in
// the same cycle that the result becomes valid; one shared multiplier and one restoring divider (one
// quotient bit a cycle) serve the channels in turn, a channel with no fade running skips both
// a setting item retargets (blends new start values) when its fade length is nonzero, then
// converts its bytes to targets; one word at a time; a liquid override skips the blend
// reset: fog returns to zero density and 0.3 gray, no fade running, water fog off
`default_nettype none

module timed_fog_crossfade #(
  parameter int unsigned FRACTION_BITS = tfc_pkg::FRACTION_BITS_DEF,
  parameter int unsigned TIME_BITS     = tfc_pkg::TIME_BITS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  tfc_stream_if.sink      in_i,
  tfc_stream_if.source    out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_data_i
);

  localparam int unsigned FB   = FRACTION_BITS;
  localparam int unsigned TB   = TIME_BITS;
  localparam int unsigned SB   = tfc_pkg::SPAN_BITS;
  localparam int unsigned NW   = FB + SB;
  localparam int unsigned GRAY = ((3 << FRACTION_BITS) + 5) / 10;
  localparam logic [FB-1:0] FMAX = {FB{1'b1}};

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REM  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_CONV = 4'd5;
  localparam logic [3:0] S_CDIV = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic PASS_START = 1'b0;
  localparam logic PASS_OUT   = 1'b1;

  logic [3:0]       state_q, state_d;
  logic             pass_q, pass_d;
  logic [1:0]       ch_q, ch_d;
  logic [1:0]       wfm_q, wfm_d;
  logic [FB-1:0]    start_q [4];
  logic [FB-1:0]    start_d [4];
  logic [FB-1:0]    target_q [4];
  logic [FB-1:0]    target_d [4];
  logic [SB-1:0]    span_q, span_d;
  logic [TB-1:0]    end_q, end_d;
  logic             out_valid_q, out_valid_d;

  tfc_pkg::tfc_in_t  item_q, item_d;
  tfc_pkg::tfc_out_t out_q, out_d;
  logic [SB-1:0]     r_q, r_d;
  logic [NW-1:0]     acc_q, acc_d;
  logic [7:0]        res_q [4];
  logic [7:0]        res_d [4];

  logic              div_start;
  logic [NW-1:0]     div_numer;
  logic [SB-1:0]     div_divisor;
  logic              div_done;
  logic [FB-1:0]     div_quot;

  logic [FB-1:0]     mul_a;
  logic [SB-1:0]     mul_b;
  logic [NW-1:0]     mul_p;

  logic [TB-1:0]     now_t;
  logic [TB-1:0]     diff;
  logic              r_active;
  logic [SB-1:0]     r_val;
  logic [FB-1:0]     s_cur;
  logic [FB-1:0]     t_cur;
  logic [FB-1:0]     bl_val;
  logic [FB+7:0]     bl_scaled;
  logic [7:0]        bl_byte;
  logic [7:0]        ch_byte;
  logic [1:0]        mode_eff;
  logic              override;
  tfc_pkg::rgb_t     liquid;

  tfc_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .numer_i  (div_numer),
    .divisor_i(div_divisor),
    .done_o   (div_done),
    .quot_o   (div_quot)
  );

  assign now_t    = TB'({{TB{1'b0}}, item_q.now});
  assign diff     = end_q - now_t;
  assign r_active = (span_q != '0) && (diff != '0) && !diff[TB-1];
  assign r_val    = !r_active ? '0 : ((diff > TB'(span_q)) ? span_q : diff[SB-1:0]);

  assign s_cur = start_q[ch_q];
  assign t_cur = target_q[ch_q];
  assign mul_p = {{SB{1'b0}}, mul_a} * {{FB{1'b0}}, mul_b};

  // v * 255 rounded back to a byte
  assign bl_val    = (state_q == S_DIV) ? div_quot : t_cur;
  assign bl_scaled = (FB+8)'({bl_val, 8'd0}) - (FB+8)'(bl_val)
                   + (FB+8)'(1 << (FB - 1));
  assign bl_byte   = bl_scaled[FB+7:FB];

  always_comb begin
    case (ch_q)
      2'd0:    ch_byte = item_q.new_density;
      2'd1:    ch_byte = item_q.new_red;
      2'd2:    ch_byte = item_q.new_green;
      default: ch_byte = item_q.new_blue;
    endcase
  end

  assign mode_eff = (wfm_q == 2'd3) ? tfc_pkg::FOG_MODE_WATER_EXP : wfm_q;
  assign override = (mode_eff != tfc_pkg::FOG_MODE_GLOBAL)
                 && (item_q.view_contents != tfc_pkg::VIEW_EMPTY)
                 && (item_q.view_contents != tfc_pkg::VIEW_SOLID);
  assign liquid   = tfc_pkg::liquid_colour(item_q.view_contents);

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    ch_d        = ch_q;
    wfm_d       = cfg_we_i ? cfg_data_i : wfm_q;
    start_d     = start_q;
    target_d    = target_q;
    span_d      = span_q;
    end_d       = end_q;
    out_valid_d = out_valid_q;
    item_d      = item_q;
    out_d       = out_q;
    r_d         = r_q;
    acc_d       = acc_q;
    res_d       = res_q;
    div_start   = 1'b0;
    div_numer   = acc_q;
    div_divisor = span_q;
    mul_a       = s_cur;
    mul_b       = r_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          item_d = in_i.data;
          ch_d   = 2'd0;
          pass_d = PASS_START;
          if (in_i.data.kind == tfc_pkg::KIND_SETTING) begin
            state_d = (in_i.data.fade_length != '0) ? S_REM : S_CONV;
          end else begin
            state_d = S_CHK;
          end
        end
      end
      S_REM: begin
        r_d     = r_val;
        ch_d    = 2'd0;
        state_d = S_MUL1;
      end
      S_MUL1, S_DIV: begin
        if ((state_q == S_MUL1) && (r_q != '0)) begin
          acc_d   = mul_p + NW'(span_q >> 1);
          state_d = S_MUL2;
        end else if ((state_q == S_MUL1) || div_done) begin
          if (pass_q == PASS_START) begin
            start_d[ch_q] = bl_val;
          end else begin
            res_d[ch_q] = bl_byte;
          end
          if (ch_q == 2'd3) begin
            ch_d    = 2'd0;
            state_d = (pass_q == PASS_START) ? S_CONV : S_OUT;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_MUL1;
          end
        end
      end
      S_MUL2: begin
        mul_a       = t_cur;
        mul_b       = span_q - r_q;
        div_start   = 1'b1;
        div_numer   = acc_q + mul_p;
        div_divisor = span_q;
        state_d     = S_DIV;
      end
      S_CONV, S_CDIV: begin
        if ((state_q == S_CONV) && (ch_byte != 8'd255)) begin
          div_start   = 1'b1;
          div_numer   = NW'({ch_byte, FB'(127)});
          div_divisor = SB'(255);
          state_d     = S_CDIV;
        end else if ((state_q == S_CONV) || div_done) begin
          target_d[ch_q] = (state_q == S_CONV) ? FMAX : div_quot;
          if (ch_q == 2'd3) begin
            ch_d    = 2'd0;
            span_d  = item_q.fade_length;
            end_d   = now_t + TB'(item_q.fade_length);
            state_d = S_CHK;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_CONV;
          end
        end
      end
      S_CHK: begin
        if (override) begin
          res_d[0] = 8'd255;
          res_d[1] = liquid.red;
          res_d[2] = liquid.green;
          res_d[3] = liquid.blue;
          state_d  = S_OUT;
        end else begin
          pass_d  = PASS_OUT;
          state_d = S_REM;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d.out_density  = res_q[0];
          out_d.out_red      = res_q[1];
          out_d.out_green    = res_q[2];
          out_d.out_blue     = res_q[3];
          out_d.water_active = override;
          out_d.fog_mode     = override ? mode_eff : tfc_pkg::FOG_MODE_GLOBAL;
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_START;
      ch_q        <= '0;
      wfm_q       <= tfc_pkg::FOG_MODE_GLOBAL;
      start_q[0]  <= '0;
      target_q[0] <= '0;
      for (int i = 1; i < 4; i++) begin
        start_q[i]  <= FB'(GRAY);
        target_q[i] <= FB'(GRAY);
      end
      span_q      <= '0;
      end_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      ch_q        <= ch_d;
      wfm_q       <= wfm_d;
      start_q     <= start_d;
      target_q    <= target_d;
      span_q      <= span_d;
      end_q       <= end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    out_q  <= out_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

`default_nettype wire
